// ===== sv/pileup_base_quality_stats_defines.svh =====
// assertion macros for the pileup statistics block
// no dependencies; included by modules that carry assertions
`ifndef PILEUP_BASE_QUALITY_STATS_DEFINES_SVH
`define PILEUP_BASE_QUALITY_STATS_DEFINES_SVH
`ifndef SYNTHESIS
`define PBQS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbqs assertion failed");
`define PBQS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbqs assertion failed");
`else
`define PBQS_ASSERT_IMP(lbl, ante, cons)
`define PBQS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/pbqs_pkg.sv =====
// shared types, constants and codes for the pileup statistics block
// no dependencies
`default_nettype none
package pbqs_pkg;
    localparam int NUM_POSITIONS = 1024;
    localparam int QUALITY_BINS  = 128;
    localparam int POS_W         = 10;
    localparam int BIN_W         = $clog2(QUALITY_BINS);
    localparam int HIST_AW       = POS_W + BIN_W;
    localparam int CNT_W         = 32;
    localparam int NUM_BASES     = 5;
    localparam int BASE_ROW_W    = NUM_BASES * CNT_W;
    localparam int BINS_W        = 8;
    localparam int CUM_W         = 40;
    localparam int SUM_W         = 48;
    localparam int PCT_W         = 46;
    localparam int NUM_PCT       = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [8:0] PHRED_OFFSET = 9'd33;

    localparam logic [1:0] REQ_BASE   = 2'd0;
    localparam logic [1:0] REQ_QUAL   = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_BASE = 2'd1;
    localparam logic [1:0] STAT_BAD_QUAL = 2'd2;

    localparam logic [2:0] BASE_A   = 3'd0;
    localparam logic [2:0] BASE_C   = 3'd1;
    localparam logic [2:0] BASE_G   = 3'd2;
    localparam logic [2:0] BASE_T   = 3'd3;
    localparam logic [2:0] BASE_N   = 3'd4;
    localparam logic [2:0] BASE_BAD = 3'd5;

    // median, lower quartile, upper quartile, 5 percent, 95 percent
    localparam logic [4:0] PCT_SCALE [NUM_PCT] = '{5'd2, 5'd4, 5'd4, 5'd20, 5'd20};
    localparam logic [4:0] PCT_PART  [NUM_PCT] = '{5'd1, 5'd1, 5'd3, 5'd1, 5'd19};

    typedef struct packed {
        logic [1:0]       req_type;
        logic [POS_W-1:0] position;
        logic [7:0]       symbol_char;
        logic             reverse_strand;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        major_base;
        logic [CNT_W-1:0]  major_count;
        logic [CNT_W-1:0]  second_count;
        logic [CNT_W-1:0]  coverage;
        logic [CNT_W-1:0]  floor_coverage;
        logic [6:0]        mean_phred;
        logic signed [7:0] median_phred;
        logic signed [7:0] lower_quartile;
        logic signed [7:0] upper_quartile;
        logic signed [7:0] low_five_pct;
        logic signed [7:0] high_95_pct;
    } out_item_t;

    typedef struct packed {
        logic                  we;
        logic [POS_W-1:0]      waddr;
        logic [BASE_ROW_W-1:0] wdata;
        logic [POS_W-1:0]      raddr;
    } base_mem_req_t;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [BINS_W-1:0] wdata;
        logic [POS_W-1:0]  raddr;
    } bins_mem_req_t;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [CNT_W-1:0]   wdata;
        logic [HIST_AW-1:0] raddr;
    } hist_mem_req_t;
endpackage
`default_nettype wire

// ===== sv/pbqs_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module pbqs_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== sv/pbqs_core.sv =====
// sequencer: read-modify-write of counters, histogram walk, mean divider
// depends on pbqs_pkg and pileup_base_quality_stats_defines.svh
`default_nettype none
`include "pileup_base_quality_stats_defines.svh"
module pbqs_core import pbqs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  in_item_t              req,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [6:0]            cfg_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output out_item_t             res,
    output base_mem_req_t         base_mem,
    input  logic [BASE_ROW_W-1:0] base_rdata,
    output bins_mem_req_t         bins_mem,
    input  logic [BINS_W-1:0]     bins_rdata,
    output hist_mem_req_t         hist_mem,
    input  logic [CNT_W-1:0]      hist_rdata
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MOD, ST_WALK, ST_RES, ST_DIV, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [1:0]         status_reg, status_next;
    logic               rep_reg, rep_next;
    logic               clr_active_reg, clr_active_next;
    logic [HIST_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [6:0]         floor_reg, floor_next;
    logic [CNT_W-1:0]   cov_reg, cov_next;
    logic [CNT_W-1:0]   mx_reg, mx_next;
    logic [CNT_W-1:0]   sec_reg, sec_next;
    logic [2:0]         major_reg, major_next;
    logic [BINS_W-1:0]  len_reg, len_next;
    logic [BINS_W-1:0]  walk_j_reg, walk_j_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [BIN_W-1:0]   proc_j_reg, proc_j_next;
    logic [CUM_W-1:0]   cum_reg, cum_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   fc_reg, fc_next;
    logic [NUM_PCT-1:0] pt_set_reg, pt_set_next;
    logic [NUM_PCT-1:0] pt_pend_reg, pt_pend_next;
    logic [7:0]         pt_val_reg [NUM_PCT];
    logic [7:0]         pt_val_next [NUM_PCT];
    logic [BIN_W-1:0]   pend_j_reg, pend_j_next;
    logic [2:0]         div_i_reg, div_i_next;
    logic [6:0]         quot_reg, quot_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    out_item_t          res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    function automatic logic [2:0] decode_base(input logic [7:0] ch, input logic rev);
        logic [2:0] b;
        b = BASE_BAD;
        case (ch)
            "A", "a": b = BASE_A;
            "C", "c": b = BASE_C;
            "G", "g": b = BASE_G;
            "T", "t": b = BASE_T;
            "N", "X", "-": b = BASE_N;
            default: b = BASE_BAD;
        endcase
        if (rev && b < BASE_N)
        begin
            b = BASE_T - b;
        end
        return b;
    endfunction

    function automatic logic [7:0] mid_point(input logic [BIN_W-1:0] a,
                                             input logic [BINS_W-1:0] k);
        logic [BINS_W:0] s;
        s = {2'b00, a} + {1'b0, k};
        s = s >> 1;
        return (s > 9'd127) ? 8'd127 : s[7:0];
    endfunction

    logic [2:0]        bcode;
    logic [8:0]        qv9;
    logic              in_range;
    logic [2:0]        bcode_item;
    logic [8:0]        qv9_item;
    logic              item_in_range;
    logic [BASE_ROW_W-1:0] row;
    logic [CNT_W+2:0]  cov_sum;
    logic [CNT_W-1:0]  cnt_b;
    logic [CNT_W-1:0]  mx, sec;
    logic [2:0]        maj;
    logic [BINS_W-1:0] binsv;
    logic [CNT_W-1:0]  e;
    logic [CUM_W-1:0]  cum_n;
    logic [PCT_W-1:0]  lhs, rhs;
    logic              new_pend;
    logic [SUM_W-1:0]  num, dsh;
    logic [SUM_W-1:0]  den;

    assign bcode         = decode_base(req.symbol_char, req.reverse_strand);
    assign qv9           = {1'b0, req.symbol_char} - PHRED_OFFSET;
    assign in_range      = ({1'b0, req.position} < (POS_W+1)'(NUM_POSITIONS));
    assign bcode_item    = decode_base(item_reg.symbol_char, item_reg.reverse_strand);
    assign qv9_item      = {1'b0, item_reg.symbol_char} - PHRED_OFFSET;
    assign item_in_range = ({1'b0, item_reg.position} < (POS_W+1)'(NUM_POSITIONS));

    assign req_ready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        rep_next        = rep_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        floor_next      = floor_reg;
        cov_next        = cov_reg;
        mx_next         = mx_reg;
        sec_next        = sec_reg;
        major_next      = major_reg;
        len_next        = len_reg;
        walk_j_next     = walk_j_reg;
        proc_valid_next = 1'b0;
        proc_j_next     = proc_j_reg;
        cum_next        = cum_reg;
        sum_next        = sum_reg;
        fc_next         = fc_reg;
        pt_set_next     = pt_set_reg;
        pt_pend_next    = pt_pend_reg;
        pt_val_next     = pt_val_reg;
        pend_j_next     = pend_j_reg;
        div_i_next      = div_i_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        base_mem        = '0;
        bins_mem        = '0;
        hist_mem        = '0;
        row             = base_rdata;
        cov_sum         = '0;
        cnt_b           = '0;
        mx              = '0;
        sec             = '0;
        maj             = BASE_A;
        binsv           = '0;
        e               = hist_rdata;
        cum_n           = '0;
        lhs             = '0;
        rhs             = '0;
        new_pend        = 1'b0;
        den             = SUM_W'({cov_reg, 1'b0});
        num             = '0;
        dsh             = '0;

        if (cfg_valid && cfg_ready)
        begin
            floor_next = cfg_data;
        end
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // clearing pass over all stores after reset
        if (clr_active_reg)
        begin
            hist_mem.we    = 1'b1;
            hist_mem.waddr = clr_addr_reg;
            hist_mem.wdata = '0;
            if (clr_addr_reg[HIST_AW-1:POS_W] == '0)
            begin
                base_mem.we    = 1'b1;
                base_mem.waddr = clr_addr_reg[POS_W-1:0];
                base_mem.wdata = '0;
                bins_mem.we    = 1'b1;
                bins_mem.waddr = clr_addr_reg[POS_W-1:0];
                bins_mem.wdata = '0;
            end
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {HIST_AW{1'b1}})
            begin
                clr_active_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    item_next   = req;
                    status_next = STAT_OK;
                    rep_next    = 1'b0;
                    state_next  = ST_FIN;
                    unique case (req.req_type)
                        REQ_BASE:
                        begin
                            if (bcode == BASE_BAD)
                            begin
                                status_next = STAT_BAD_BASE;
                            end
                            else if (in_range)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        REQ_QUAL:
                        begin
                            if (req.symbol_char < 8'd33 || qv9 >= 9'(QUALITY_BINS))
                            begin
                                status_next = STAT_BAD_QUAL;
                            end
                            else if (in_range)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        REQ_REPORT:
                        begin
                            rep_next   = 1'b1;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                base_mem.raddr = item_reg.position;
                bins_mem.raddr = item_reg.position;
                hist_mem.raddr = {item_reg.position, qv9_item[BIN_W-1:0]};
                state_next     = ST_MOD;
            end
            ST_MOD:
            begin
                if (!item_in_range)
                begin
                    row = '0;
                end
                for (int b = 0; b < NUM_BASES; b++)
                begin
                    cov_sum = cov_sum + (CNT_W+3)'(row[b*CNT_W +: CNT_W]);
                end
                case (item_reg.req_type)
                    REQ_BASE:
                    begin
                        state_next = ST_FIN;
                        if (cov_sum < (CNT_W+3)'(CNT_MAX))
                        begin
                            cnt_b = row[bcode_item*CNT_W +: CNT_W] + 1'b1;
                            row[bcode_item*CNT_W +: CNT_W] = cnt_b;
                            base_mem.we    = 1'b1;
                            base_mem.waddr = item_reg.position;
                            base_mem.wdata = row;
                        end
                    end
                    REQ_QUAL:
                    begin
                        state_next     = ST_FIN;
                        hist_mem.we    = 1'b1;
                        hist_mem.waddr = {item_reg.position, qv9_item[BIN_W-1:0]};
                        hist_mem.wdata = (hist_rdata < CNT_MAX) ? hist_rdata + 1'b1
                                                                : hist_rdata;
                        bins_mem.we    = 1'b1;
                        bins_mem.waddr = item_reg.position;
                        bins_mem.wdata = (qv9_item[BINS_W-1:0] + 1'b1 > bins_rdata)
                                         ? qv9_item[BINS_W-1:0] + 1'b1 : bins_rdata;
                    end
                    default:
                    begin
                        mx  = row[0 +: CNT_W];
                        sec = row[CNT_W +: CNT_W];
                        maj = BASE_A;
                        if (mx < row[CNT_W +: CNT_W])
                        begin
                            sec = mx;
                            mx  = row[CNT_W +: CNT_W];
                            maj = BASE_C;
                        end
                        for (int b = 2; b < NUM_BASES; b++)
                        begin
                            if (mx < row[b*CNT_W +: CNT_W])
                            begin
                                sec = mx;
                                mx  = row[b*CNT_W +: CNT_W];
                                maj = 3'(b);
                            end
                            else if (row[b*CNT_W +: CNT_W] > sec)
                            begin
                                sec = row[b*CNT_W +: CNT_W];
                            end
                        end
                        binsv = item_in_range ? bins_rdata : '0;
                        mx_next     = mx;
                        sec_next    = sec;
                        major_next  = maj;
                        cov_next    = cov_sum[CNT_W-1:0];
                        len_next    = (binsv > BINS_W'(QUALITY_BINS))
                                      ? BINS_W'(QUALITY_BINS) : binsv;
                        walk_j_next = '0;
                        cum_next    = '0;
                        sum_next    = '0;
                        fc_next     = '0;
                        pt_set_next  = '0;
                        pt_pend_next = '0;
                        for (int p = 0; p < NUM_PCT; p++)
                        begin
                            pt_val_next[p] = '0;
                        end
                        state_next = ST_WALK;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (walk_j_reg < len_reg)
                begin
                    hist_mem.raddr  = {item_reg.position, walk_j_reg[BIN_W-1:0]};
                    proc_valid_next = 1'b1;
                    proc_j_next     = walk_j_reg[BIN_W-1:0];
                    walk_j_next     = walk_j_reg + 1'b1;
                end
                else if (!proc_valid_reg)
                begin
                    state_next = ST_RES;
                end
                if (proc_valid_reg)
                begin
                    cum_n    = cum_reg + CUM_W'(e);
                    cum_next = cum_n;
                    sum_next = sum_reg + SUM_W'((CNT_W+BIN_W)'(e)
                                                * (CNT_W+BIN_W)'(proc_j_reg));
                    if (floor_reg != '0 && {1'b0, floor_reg} == {1'b0, proc_j_reg} + 8'd1)
                    begin
                        fc_next = (CUM_W'(cov_reg) > cum_n) ? cov_reg - cum_n[CNT_W-1:0]
                                                            : '0;
                    end
                    for (int p = 0; p < NUM_PCT; p++)
                    begin
                        lhs = PCT_W'(cum_n) * PCT_W'(PCT_SCALE[p]);
                        rhs = PCT_W'(cov_reg) * PCT_W'(PCT_PART[p]);
                        if (pt_pend_reg[p])
                        begin
                            if (e != '0)
                            begin
                                pt_val_next[p]  = mid_point(pend_j_reg, {1'b0, proc_j_reg});
                                pt_pend_next[p] = 1'b0;
                                pt_set_next[p]  = 1'b1;
                            end
                        end
                        else if (!pt_set_reg[p])
                        begin
                            if (lhs > rhs)
                            begin
                                pt_val_next[p] = {1'b0, proc_j_reg};
                                pt_set_next[p] = 1'b1;
                            end
                            else if (lhs == rhs)
                            begin
                                pt_pend_next[p] = 1'b1;
                                new_pend        = 1'b1;
                            end
                        end
                    end
                    if (new_pend)
                    begin
                        pend_j_next = proc_j_reg;
                    end
                end
            end
            ST_RES:
            begin
                for (int p = 0; p < NUM_PCT; p++)
                begin
                    if (pt_pend_reg[p])
                    begin
                        pt_val_next[p]  = mid_point(pend_j_reg, len_reg);
                        pt_pend_next[p] = 1'b0;
                        pt_set_next[p]  = 1'b1;
                    end
                end
                num        = {sum_reg[SUM_W-2:0], 1'b0} + SUM_W'(cov_reg);
                quot_next  = '0;
                rem_next   = num;
                div_i_next = 3'd6;
                if (cov_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else if (num >= (den << 7))
                begin
                    quot_next  = 7'd127;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dsh = den << div_i_reg;
                if (rem_reg >= dsh)
                begin
                    rem_next             = rem_reg - dsh;
                    quot_next[div_i_reg] = 1'b1;
                end
                if (div_i_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_i_next = div_i_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next        = '0;
                    res_next.status = status_reg;
                    if (rep_reg)
                    begin
                        res_next.major_base     = major_reg;
                        res_next.major_count    = mx_reg;
                        res_next.second_count   = sec_reg;
                        res_next.coverage       = cov_reg;
                        res_next.floor_coverage = fc_reg;
                        res_next.mean_phred     = quot_reg;
                        res_next.median_phred   = pt_set_reg[0] ? pt_val_reg[0] : 8'hFF;
                        res_next.lower_quartile = pt_set_reg[1] ? pt_val_reg[1] : 8'hFF;
                        res_next.upper_quartile = pt_set_reg[2] ? pt_val_reg[2] : 8'hFF;
                        res_next.low_five_pct   = pt_set_reg[3] ? pt_val_reg[3] : 8'hFF;
                        res_next.high_95_pct    = pt_set_reg[4] ? pt_val_reg[4] : 8'hFF;
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            floor_reg      <= '0;
            res_valid_reg  <= 1'b0;
            proc_valid_reg <= 1'b0;
            rep_reg        <= 1'b0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            floor_reg      <= floor_next;
            res_valid_reg  <= res_valid_next;
            proc_valid_reg <= proc_valid_next;
            rep_reg        <= rep_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cov_reg     <= cov_next;
        mx_reg      <= mx_next;
        sec_reg     <= sec_next;
        major_reg   <= major_next;
        len_reg     <= len_next;
        walk_j_reg  <= walk_j_next;
        proc_j_reg  <= proc_j_next;
        cum_reg     <= cum_next;
        sum_reg     <= sum_next;
        fc_reg      <= fc_next;
        pt_set_reg  <= pt_set_next;
        pt_pend_reg <= pt_pend_next;
        pt_val_reg  <= pt_val_next;
        pend_j_reg  <= pend_j_next;
        div_i_reg   <= div_i_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
    end

    `PBQS_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready)
    `PBQS_ASSERT_IMP(a_walk_bound, state_reg == ST_WALK && proc_valid_reg, {1'b0, proc_j_reg} < len_reg)
    `PBQS_ASSERT_IMP(a_div_cov, state_reg == ST_DIV, cov_reg != '0)
endmodule
`default_nettype wire

// ===== sv/pileup_base_quality_stats.sv =====
// top level of the pileup statistics block: sequencer and three rams
// depends on pbqs_pkg, pbqs_ram, pbqs_core
//
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    in_item_t
// cfg       in   cfg_valid/cfg_ready    quality floor, 7 bits
// res       out  res_valid/res_ready    out_item_t
//
// add items go through accept, ram read, write back and result register
// reports do one histogram ram read per bin in use
// plus at most a 7-step mean divider
// after reset a pass clearing 131072 addresses ends before req_ready rises
// the result register lets a new item in while the last result waits
`default_nettype none
module pileup_base_quality_stats import pbqs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  in_item_t   req,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data,
    output logic       res_valid,
    input  logic       res_ready,
    output out_item_t  res
);
    base_mem_req_t         base_mem;
    bins_mem_req_t         bins_mem;
    hist_mem_req_t         hist_mem;
    logic [BASE_ROW_W-1:0] base_rdata;
    logic [BINS_W-1:0]     bins_rdata;
    logic [CNT_W-1:0]      hist_rdata;

    pbqs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .base_mem   (base_mem),
        .base_rdata (base_rdata),
        .bins_mem   (bins_mem),
        .bins_rdata (bins_rdata),
        .hist_mem   (hist_mem),
        .hist_rdata (hist_rdata)
    );

    pbqs_ram #(.AW(POS_W), .DW(BASE_ROW_W)) u_base_ram (
        .clk   (clk),
        .we    (base_mem.we),
        .waddr (base_mem.waddr),
        .wdata (base_mem.wdata),
        .raddr (base_mem.raddr),
        .rdata (base_rdata)
    );

    pbqs_ram #(.AW(POS_W), .DW(BINS_W)) u_bins_ram (
        .clk   (clk),
        .we    (bins_mem.we),
        .waddr (bins_mem.waddr),
        .wdata (bins_mem.wdata),
        .raddr (bins_mem.raddr),
        .rdata (bins_rdata)
    );

    pbqs_ram #(.AW(HIST_AW), .DW(CNT_W)) u_hist_ram (
        .clk   (clk),
        .we    (hist_mem.we),
        .waddr (hist_mem.waddr),
        .wdata (hist_mem.wdata),
        .raddr (hist_mem.raddr),
        .rdata (hist_rdata)
    );
endmodule
`default_nettype wire

// ===== tb/pileup_base_quality_stats_test.sv =====
// self-checking testbench for pileup_base_quality_stats: directed and random transactions
// with a built-in pileup predictor, random idling on both sides and a long receiver stall
// depends on pbqs_pkg and the pileup_base_quality_stats rtl
`timescale 1ns / 1ps
`default_nettype none
module pileup_base_quality_stats_test;
    import pbqs_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    in_item_t   req;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    logic       res_valid;
    logic       res_ready;
    out_item_t  res;

    pileup_base_quality_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    logic [CNT_W-1:0] pile_bases [NUM_POSITIONS][NUM_BASES];
    logic [CNT_W-1:0] pile_hist [NUM_POSITIONS][QUALITY_BINS];
    int unsigned      pile_bins [NUM_POSITIONS];
    logic [6:0]       floor_reg;

    out_item_t   expected_results [$];
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [2:0] base_code(logic [7:0] ch, logic rev);
        logic [2:0] b;
        case (ch)
            "A", "a": b = BASE_A;
            "C", "c": b = BASE_C;
            "G", "g": b = BASE_G;
            "T", "t": b = BASE_T;
            "N", "X", "-": return BASE_N;
            default: return BASE_BAD;
        endcase
        return rev ? BASE_T - b : b;
    endfunction

    function automatic out_item_t pileup_report(int unsigned pos);
        out_item_t   r;
        longint      cnt [NUM_BASES];
        longint      cov, cum, total, fc, mx, sec, lhs, rhs;
        int          pt [NUM_PCT];
        int unsigned len, k, v, major;
        r = '0;
        cov = 0;
        cum = 0;
        total = 0;
        fc = 0;
        major = 0;
        len = pile_bins[pos];
        for (int b = 0; b < NUM_BASES; b++)
        begin
            cnt[b] = pile_bases[pos][b];
            cov += cnt[b];
        end
        for (int p = 0; p < NUM_PCT; p++)
            pt[p] = -1;
        mx = cnt[0];
        sec = cnt[1];
        if (mx < cnt[1])
        begin
            sec = mx;
            mx = cnt[1];
            major = 1;
        end
        for (int b = 2; b < NUM_BASES; b++)
        begin
            if (mx < cnt[b])
            begin
                sec = mx;
                mx = cnt[b];
                major = b;
            end
            else if (cnt[b] > sec)
                sec = cnt[b];
        end
        for (int unsigned j = 0; j < len; j++)
        begin
            cum += pile_hist[pos][j];
            total += longint'(j) * pile_hist[pos][j];
            if (floor_reg != 0 && floor_reg == j + 1)
                fc = (cov > cum) ? cov - cum : 0;
            for (int p = 0; p < NUM_PCT; p++)
            begin
                if (pt[p] < 0)
                begin
                    lhs = PCT_SCALE[p] * cum;
                    rhs = PCT_PART[p] * cov;
                    if (lhs >= rhs)
                    begin
                        if (lhs > rhs)
                            v = j;
                        else
                        begin
                            k = j + 1;
                            while (k < len && pile_hist[pos][k] == 0)
                                k++;
                            v = (j + k) / 2;
                        end
                        pt[p] = (v > 127) ? 127 : v;
                    end
                end
            end
        end
        r.status         = STAT_OK;
        r.major_base     = major[2:0];
        r.major_count    = mx[CNT_W-1:0];
        r.second_count   = sec[CNT_W-1:0];
        r.coverage       = cov[CNT_W-1:0];
        r.floor_coverage = fc[CNT_W-1:0];
        if (cov > 0)
            r.mean_phred = ((2 * total + cov) / (2 * cov) > 127) ? 7'd127
                           : 7'((2 * total + cov) / (2 * cov));
        r.median_phred   = 8'(pt[0]);
        r.lower_quartile = 8'(pt[1]);
        r.upper_quartile = 8'(pt[2]);
        r.low_five_pct   = 8'(pt[3]);
        r.high_95_pct    = 8'(pt[4]);
        return r;
    endfunction

    function automatic out_item_t pileup_apply(in_item_t it);
        out_item_t   r;
        logic [2:0]  b;
        longint      cov;
        int unsigned q;
        r = '0;
        case (it.req_type)
            REQ_BASE:
            begin
                b = base_code(it.symbol_char, it.reverse_strand);
                if (b == BASE_BAD)
                    r.status = STAT_BAD_BASE;
                else
                begin
                    cov = 0;
                    for (int i = 0; i < NUM_BASES; i++)
                        cov += pile_bases[it.position][i];
                    if (cov < CNT_MAX)
                        pile_bases[it.position][b]++;
                end
            end
            REQ_QUAL:
            begin
                if (it.symbol_char < PHRED_OFFSET
                    || it.symbol_char - PHRED_OFFSET >= QUALITY_BINS)
                    r.status = STAT_BAD_QUAL;
                else
                begin
                    q = it.symbol_char - PHRED_OFFSET;
                    if (pile_hist[it.position][q] != CNT_MAX)
                        pile_hist[it.position][q]++;
                    if (q + 1 > pile_bins[it.position])
                        pile_bins[it.position] = q + 1;
                end
            end
            REQ_REPORT:
                r = pileup_report(it.position);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_results.push_back(pileup_apply(it));
    endtask

    task automatic send(logic [1:0] t, logic [9:0] pos, logic [7:0] ch, logic rev);
        in_item_t it;
        it.req_type       = t;
        it.position       = pos;
        it.symbol_char    = ch;
        it.reverse_strand = rev;
        send_item(it);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_floor(logic [6:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        floor_reg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned sel;
        string       letters;
        letters = "ACGTacgtNX-";
        sel = $urandom_range(99);
        it.reverse_strand = 1'($urandom_range(1));
        it.position = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
        if (sel < 38)
        begin
            it.req_type = REQ_BASE;
            it.symbol_char = ($urandom_range(9) == 0) ? 8'($urandom)
                             : letters[$urandom_range(letters.len() - 1)];
        end
        else if (sel < 76)
        begin
            it.req_type = REQ_QUAL;
            it.symbol_char = ($urandom_range(9) == 0) ? 8'($urandom)
                             : ($urandom_range(3) == 0) ? 8'($urandom_range(160, 33))
                             : 8'($urandom_range(75, 33));
        end
        else if (sel < 96)
        begin
            it.req_type = REQ_REPORT;
            it.symbol_char = 8'($urandom);
        end
        else
        begin
            it.req_type = REQ_UNUSED;
            it.symbol_char = 8'($urandom);
        end
        return it;
    endfunction

    task automatic random_items(int unsigned count);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_bases();
        string letters;
        letters = "ACGTacgtNX-";
        for (int i = 0; i < letters.len(); i++)
            send(REQ_BASE, 10'd1, letters[i], i[0]);
        send(REQ_BASE, 10'd1, 8'd0, 1'b0);
        send(REQ_BASE, 10'd1, 8'd255, 1'b1);
        send(REQ_BASE, 10'd1023, "B", 1'b0);
        send(REQ_BASE, 10'd1023, "T", 1'b1);
        send(REQ_UNUSED, 10'd1, "A", 1'b1);
        send(REQ_REPORT, 10'd1, 8'd0, 1'b0);
        send(REQ_REPORT, 10'd1023, 8'd255, 1'b1);
    endtask

    task automatic test_qualities();
        send(REQ_QUAL, 10'd2, 8'd32, 1'b0);
        send(REQ_QUAL, 10'd2, 8'd161, 1'b0);
        send(REQ_QUAL, 10'd2, 8'd0, 1'b0);
        send(REQ_QUAL, 10'd2, 8'd255, 1'b1);
        send(REQ_QUAL, 10'd2, 8'd33, 1'b0);
        send(REQ_QUAL, 10'd2, 8'd160, 1'b0);
        send(REQ_BASE, 10'd2, "G", 1'b0);
        send(REQ_BASE, 10'd2, "G", 1'b0);
        send(REQ_REPORT, 10'd2, 8'd0, 1'b0);
        send(REQ_REPORT, 10'd500, 8'd0, 1'b0);
    endtask

    task automatic test_floor_settings();
        logic [6:0] floors [4];
        floors = '{7'd127, 7'd1, 7'd20, 7'd0};
        foreach (floors[i])
        begin
            write_floor(floors[i]);
            for (int p = 0; p < 8; p++)
                send(REQ_REPORT, 10'(p), 8'd0, 1'b0);
            random_items(30);
        end
    endtask

    task automatic test_random_idling();
        send_idle_pct = 34;
        recv_idle_pct = 52;
        random_items(600);
        send_idle_pct = 52;
        recv_idle_pct = 34;
        random_items(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(500);
    endtask

    task automatic test_receiver_stall();
        stall_cycles = 400;
        random_items(60);
    endtask

    always @(posedge clk)
    begin
        if (stall_cycles > 0)
        begin
            stall_cycles <= stall_cycles - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %p", res);
            end
            else
            begin
                automatic out_item_t want = expected_results.pop_front();
                if (res.status !== want.status || res.major_base !== want.major_base
                    || res.major_count !== want.major_count
                    || res.second_count !== want.second_count
                    || res.coverage !== want.coverage
                    || res.floor_coverage !== want.floor_coverage
                    || res.mean_phred !== want.mean_phred
                    || res.median_phred !== want.median_phred
                    || res.lower_quartile !== want.lower_quartile
                    || res.upper_quartile !== want.upper_quartile
                    || res.low_five_pct !== want.low_five_pct
                    || res.high_95_pct !== want.high_95_pct)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", want, res);
                end
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("pileup_base_quality_stats_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        res_ready = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        send_idle_pct = 34;
        recv_idle_pct = 52;
        floor_reg = '0;
        foreach (pile_bases[p, b])
            pile_bases[p][b] = '0;
        foreach (pile_hist[p, j])
            pile_hist[p][j] = '0;
        foreach (pile_bins[p])
            pile_bins[p] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_bases();
        test_qualities();
        test_floor_settings();
        test_receiver_stall();
        test_random_idling();
        drain();
        if (mismatches == 0)
            $display("pileup_base_quality_stats_test: PASS");
        else
            $display("pileup_base_quality_stats_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/pbqs_pkg.sv
sv/pbqs_ram.sv
sv/pbqs_core.sv
sv/pileup_base_quality_stats.sv
tb/pileup_base_quality_stats_test.sv
